FILE: rtl/nbgs_pkg.sv
// Shared constants, widths and helpers for the n-body gravity step core.
package nbgs_pkg;

  localparam int DEF_MAX_PARTICLES = 1024;

  // Fixed-point layout of positions and mass
  localparam int FRAC_BITS = 16;
  localparam int MASS_FRAC = 16;
  localparam int HALF_SHIFT = FRAC_BITS / 2;
  localparam int FINE_BITS = FRAC_BITS - HALF_SHIFT;
  localparam int MAG_SHIFT = 2 * FINE_BITS + FRAC_BITS - MASS_FRAC;

  // Pair datapath widths
  localparam int AW = 33 - HALF_SHIFT;              // |delta| >> HALF_SHIFT
  localparam int SSW = 2 * AW + 1;                  // squared distance
  localparam int RW = (SSW + 1) / 2;                // its square root
  localparam int M2W = 48 - MASS_FRAC;              // mass^2, Q.16
  localparam int NUMW = M2W + MAG_SHIFT;            // pull numerator
  localparam int MAGW = NUMW - 2 * FINE_BITS;       // pull magnitude
  localparam int PRODW = MAGW + AW;                 // magnitude * axis delta
  localparam int DLY = MAGW - RW;                   // root alignment to the divider
  localparam logic [SSW-1:0] QMIN = SSW'(1) << (2 * FINE_BITS);
  localparam logic [33:0] PULL_CLAMP = 34'h1_FFFF_FFFF;

  // Stream widths
  localparam int IN_TDW = 80;
  localparam int OUT_TDW = 72;
  localparam int CFG_IDXW = 1;
  localparam int CFG_DW = 24;

  // Operation codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Register indexes
  localparam logic [CFG_IDXW-1:0] CFG_PARTICLE_COUNT = 1'b0;
  localparam logic [CFG_IDXW-1:0] CFG_PARTICLE_MASS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FORCE,
    S_DRAIN,
    S_UPDATE,
    S_UPWAIT,
    S_RESP
  } state_t;

  // Saturate to 32 signed bits; bit 32 of the result flags saturation.
  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] res;
    if (v > 36'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -36'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/nbgs_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered.
module nbgs_div_cell #(
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [DW+QW:0]    in_rem,
  input  logic [DW-1:0]     in_dvs,
  input  logic [SW-1:0]     in_side,
  output logic              out_v,
  output logic [DW+QW:0]    out_rem,
  output logic [DW-1:0]     out_dvs,
  output logic [SW-1:0]     out_side
);

  logic [DW+QW:0] sh;
  logic [DW+1:0]  diff;
  logic [DW+QW:0] rem_nxt;
  logic           v_r;
  logic [DW+QW:0] rem_r;
  logic [DW-1:0]  dvs_r;
  logic [SW-1:0]  side_r;

  // rem holds {partial remainder, numerator bits left / quotient bits so far}
  always_comb begin
    sh = {in_rem[DW+QW-1:0], 1'b0};
    diff = {1'b0, sh[DW+QW:QW]} - {2'b00, in_dvs};
    rem_nxt = diff[DW+1] ? sh : {diff[DW:0], sh[QW-1:1], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= in_dvs;
    side_r <= in_side;
  end

  assign out_v = v_r;
  assign out_rem = rem_r;
  assign out_dvs = dvs_r;
  assign out_side = side_r;

endmodule

FILE: rtl/nbgs_sqrt_cell.sv
// One digit-by-digit square root cell: one root bit per cell, registered.
module nbgs_sqrt_cell #(
  parameter int RW = 8
) (
  input  logic              clk,
  input  logic [RW+1:0]     in_rem,
  input  logic [RW-1:0]     in_root,
  input  logic [2*RW-1:0]   in_rad,
  output logic [RW+1:0]     out_rem,
  output logic [RW-1:0]     out_root,
  output logic [2*RW-1:0]   out_rad
);

  logic [RW+2:0]   t;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [2*RW-1:0] rad_r;

  always_comb begin
    t = {in_rem[RW:0], in_rad[2*RW-1:2*RW-2]};
    trial = {1'b0, in_root, 2'b01};
    diff = t - trial;
    ge = (t >= trial);
  end

  always_ff @(posedge clk) begin
    rem_r <= ge ? diff[RW+1:0] : t[RW+1:0];
    root_r <= {in_root[RW-2:0], ge};
    rad_r <= {in_rad[2*RW-3:0], 2'b00};
  end

  assign out_rem = rem_r;
  assign out_root = root_r;
  assign out_rad = rad_r;

endmodule

FILE: rtl/nbody_gravity_step_core.sv
// Direct-sum 2D gravity core for load (func 0), read (func 2) and step items. A step
// (func 1) streams every ordered particle pair, one per cycle, through a pipelined pair unit
// built from chains of division and square-root cells; the pair issue loop reads both ends
// of each pair from the dual-read position memory. Pulls of each particle are summed in pair
// order, then a second pass moves every particle and updates its velocity. One item is in
// work at a time.
module nbody_gravity_step_core import nbgs_pkg::*; #(
  parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TDW-1:0]   in_tdata,   // particle_index, load_x, load_y
  input  logic [1:0]          in_tuser,   // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TDW-1:0]  out_tdata,  // read_x, read_y, overflow
  output logic [1:0]          out_tuser,  // echo_func
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IDXW-1:0] cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  localparam int AIW = $clog2(MAX_PARTICLES);
  localparam int NW = $clog2(MAX_PARTICLES + 1);

  typedef struct packed {
    logic           first;
    logic           last;
    logic           fin;
    logic [AIW-1:0] p;
    logic [AW-1:0]  ax;
    logic [AW-1:0]  ay;
    logic           sx;
    logic           sy;
    logic           zf;
  } tag_t;

  localparam int TAGW = $bits(tag_t);

  // Stores
  logic signed [31:0] posx_mem [MAX_PARTICLES];
  logic signed [31:0] posy_mem [MAX_PARTICLES];
  logic signed [31:0] velx_mem [MAX_PARTICLES];
  logic signed [31:0] vely_mem [MAX_PARTICLES];
  logic signed [31:0] frcx_mem [MAX_PARTICLES];
  logic signed [31:0] frcy_mem [MAX_PARTICLES];

  state_t state_r, state_nxt;

  logic [10:0]      count_r;
  logic [CFG_DW-1:0] mass_r;
  logic [M2W-1:0]   m2_r;
  logic [AIW-1:0]   p_r, a_r, up_p_r, n_m1_r;
  logic             ov_r;
  logic             rd_ok_r;

  logic             out_tvalid_r;
  logic [1:0]       out_func_r;
  logic [31:0]      out_x_r, out_y_r;
  logic             out_ov_r;

  logic             out_free, accept, out_load, issue, upd_issue, acc_done;
  logic [1:0]       out_func_nxt;
  logic [31:0]      out_x_nxt, out_y_nxt;
  logic             out_ov_nxt;

  logic [9:0]       in_idx;
  logic signed [31:0] in_x, in_y;
  logic             idx_ok;
  logic [NW-1:0]    n_eff;
  logic [47:0]      mass_sq;

  logic [AIW-1:0]   ra_addr, rb_addr;
  logic signed [31:0] pxa_r, pya_r, pxb_r, pyb_r, vx_rd_r, vy_rd_r, fx_rd_r, fy_rd_r;

  tag_t             iss_tag;
  logic             st1_v_r, st2_v_r, st3_v_r, st4_v_r, st5_v_r;
  tag_t             st1_tag_r, st2_tag_r, st3_tag_r, st4_tag_r, st5_tag_r;
  tag_t             st2_tag_nxt, st4_tag_nxt;
  logic signed [32:0] dx, dy;
  logic [32:0]      mdx, mdy;
  logic [2*AW-1:0]  sqx_r, sqy_r;
  logic [SSW-1:0]   s_sum;
  logic [SSW-1:0]   s_r, q_r;
  logic [NUMW-1:0]  num;

  logic [SSW+MAGW:0] mc_rem  [MAGW+1];
  logic [SSW-1:0]    mc_dvs  [MAGW+1];
  logic [TAGW-1:0]   mc_side [MAGW+1];
  logic              mc_v    [MAGW+1];

  logic [RW+1:0]     sq_rem  [RW+1];
  logic [RW-1:0]     sq_root [RW+1];
  logic [2*RW-1:0]   sq_rad  [RW+1];
  logic [RW-1:0]     rt_dly_r [DLY];

  tag_t              mc_tag;
  logic [MAGW-1:0]   mag;
  logic [PRODW-1:0]  prodx_r, prody_r;
  logic [RW-1:0]     r5_r;

  logic [RW+PRODW:0] xc_rem  [PRODW+1];
  logic [RW+PRODW:0] yc_rem  [PRODW+1];
  logic [RW-1:0]     xc_dvs  [PRODW+1];
  logic [RW-1:0]     yc_dvs  [PRODW+1];
  logic [TAGW-1:0]   xc_side [PRODW+1];
  logic              xc_v    [PRODW+1];

  tag_t              fin_tag;
  logic [PRODW-1:0]  cx, cy;
  logic [33:0]       cmx, cmy;
  logic signed [35:0] pullx, pully, sumx, sumy;
  logic [32:0]       satx, saty;
  logic signed [31:0] accx_r, accy_r;

  logic              upd_v_r;
  logic [AIW-1:0]    upd_addr_r;
  logic [32:0]       nx_sat, ny_sat, vx_sat, vy_sat;

  // ---------------- input unpack and config ----------------
  assign in_idx = in_tdata[9:0];
  assign in_x = in_tdata[41:10];
  assign in_y = in_tdata[73:42];
  assign idx_ok = (32'(in_idx) < MAX_PARTICLES);
  assign accept = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign n_eff = (32'(count_r) > MAX_PARTICLES) ? NW'(MAX_PARTICLES) : NW'(count_r);
  assign mass_sq = 48'(mass_r) * 48'(mass_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mass_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PARTICLE_COUNT: count_r <= cfg_data[10:0];
        CFG_PARTICLE_MASS:  mass_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load = 1'b0;
    out_func_nxt = in_tuser;
    out_x_nxt = '0;
    out_y_nxt = '0;
    out_ov_nxt = 1'b0;
    issue = 1'b0;
    upd_issue = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = out_free;
        if (accept) begin
          case (in_tuser)
            FUNC_STEP: begin
              if (n_eff == '0) begin
                out_load = 1'b1;
              end else begin
                state_nxt = S_FORCE;
              end
            end
            FUNC_READ: state_nxt = S_READ;
            default: out_load = 1'b1;
          endcase
        end
      end
      S_READ: begin
        out_load = 1'b1;
        out_func_nxt = FUNC_READ;
        out_x_nxt = rd_ok_r ? pxb_r : '0;
        out_y_nxt = rd_ok_r ? pyb_r : '0;
        state_nxt = S_IDLE;
      end
      S_FORCE: begin
        issue = 1'b1;
        if (iss_tag.fin) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (acc_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        upd_issue = 1'b1;
        if (up_p_r == n_m1_r) begin
          state_nxt = S_UPWAIT;
        end
      end
      S_UPWAIT: state_nxt = S_RESP;
      S_RESP: begin
        out_load = 1'b1;
        out_func_nxt = FUNC_STEP;
        out_ov_nxt = ov_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      a_r <= '0;
      up_p_r <= '0;
      n_m1_r <= '0;
      ov_r <= 1'b0;
      rd_ok_r <= 1'b0;
      m2_r <= '0;
    end else begin
      if (accept) begin
        p_r <= '0;
        a_r <= '0;
        up_p_r <= '0;
        n_m1_r <= AIW'(n_eff - NW'(1));
        ov_r <= 1'b0;
        rd_ok_r <= idx_ok;
        m2_r <= mass_sq[47:MASS_FRAC];
      end else begin
        if (issue) begin
          if (iss_tag.last) begin
            a_r <= '0;
            p_r <= p_r + AIW'(1);
          end else begin
            a_r <= a_r + AIW'(1);
          end
        end
        if (upd_issue) begin
          up_p_r <= up_p_r + AIW'(1);
        end
        if (xc_v[PRODW] && (satx[32] || saty[32])) begin
          ov_r <= 1'b1;
        end
        if (upd_v_r && (nx_sat[32] || ny_sat[32] || vx_sat[32] || vy_sat[32])) begin
          ov_r <= 1'b1;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_func_r <= out_func_nxt;
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
      out_ov_r <= out_ov_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser = out_func_r;
  assign out_tdata = {7'b0, out_ov_r, out_y_r, out_x_r};

  // ---------------- memories ----------------
  assign ra_addr = (state_r == S_UPDATE) ? up_p_r : a_r;
  assign rb_addr = (state_r == S_IDLE) ? AIW'(in_idx) : p_r;

  always_ff @(posedge clk) begin
    pxa_r <= posx_mem[ra_addr];
    pya_r <= posy_mem[ra_addr];
    pxb_r <= posx_mem[rb_addr];
    pyb_r <= posy_mem[rb_addr];
    vx_rd_r <= velx_mem[up_p_r];
    vy_rd_r <= vely_mem[up_p_r];
    fx_rd_r <= frcx_mem[up_p_r];
    fy_rd_r <= frcy_mem[up_p_r];
  end

  always_ff @(posedge clk) begin
    if (upd_v_r) begin
      posx_mem[upd_addr_r] <= nx_sat[31:0];
      posy_mem[upd_addr_r] <= ny_sat[31:0];
      velx_mem[upd_addr_r] <= vx_sat[31:0];
      vely_mem[upd_addr_r] <= vy_sat[31:0];
    end else if (accept && (in_tuser == FUNC_LOAD) && idx_ok) begin
      posx_mem[AIW'(in_idx)] <= in_x;
      posy_mem[AIW'(in_idx)] <= in_y;
      velx_mem[AIW'(in_idx)] <= '0;
      vely_mem[AIW'(in_idx)] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (xc_v[PRODW] && fin_tag.last) begin
      frcx_mem[fin_tag.p] <= satx[31:0];
      frcy_mem[fin_tag.p] <= saty[31:0];
    end
  end

  // ---------------- pair front end ----------------
  always_comb begin
    iss_tag = '0;
    iss_tag.first = (a_r == '0);
    iss_tag.last = (a_r == n_m1_r);
    iss_tag.fin = (a_r == n_m1_r) && (p_r == n_m1_r);
    iss_tag.p = p_r;
  end

  always_comb begin
    dx = 33'(pxa_r) - 33'(pxb_r);
    dy = 33'(pya_r) - 33'(pyb_r);
    mdx = dx[32] ? 33'(-dx) : 33'(dx);
    mdy = dy[32] ? 33'(-dy) : 33'(dy);
    s_sum = SSW'(sqx_r) + SSW'(sqy_r);
    num = NUMW'(m2_r) << MAG_SHIFT;
  end

  always_comb begin
    st2_tag_nxt = st1_tag_r;
    st2_tag_nxt.ax = mdx[32:HALF_SHIFT];
    st2_tag_nxt.ay = mdy[32:HALF_SHIFT];
    st2_tag_nxt.sx = dx[32];
    st2_tag_nxt.sy = dy[32];
    st4_tag_nxt = st3_tag_r;
    st4_tag_nxt.zf = (s_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      st3_v_r <= 1'b0;
      st4_v_r <= 1'b0;
    end else begin
      st1_v_r <= issue;
      st2_v_r <= st1_v_r;
      st3_v_r <= st2_v_r;
      st4_v_r <= st3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    st1_tag_r <= iss_tag;
    st2_tag_r <= st2_tag_nxt;
    st3_tag_r <= st2_tag_r;
    sqx_r <= st2_tag_r.ax * st2_tag_r.ax;
    sqy_r <= st2_tag_r.ay * st2_tag_r.ay;
    st4_tag_r <= st4_tag_nxt;
    s_r <= s_sum;
    q_r <= (s_sum < QMIN) ? QMIN : s_sum;
  end

  // ---------------- magnitude divider and root chains ----------------
  assign mc_v[0] = st4_v_r;
  assign mc_rem[0] = (SSW + MAGW + 1)'(num);
  assign mc_dvs[0] = q_r;
  assign mc_side[0] = st4_tag_r;

  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0] = (2 * RW)'(s_r);

  for (genvar i = 0; i < MAGW; i++) begin : g_mag
    nbgs_div_cell #(.DW(SSW), .QW(MAGW), .SW(TAGW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_v(mc_v[i]), .in_rem(mc_rem[i]), .in_dvs(mc_dvs[i]), .in_side(mc_side[i]),
      .out_v(mc_v[i+1]), .out_rem(mc_rem[i+1]), .out_dvs(mc_dvs[i+1]),
      .out_side(mc_side[i+1])
    );
  end

  for (genvar i = 0; i < RW; i++) begin : g_root
    nbgs_sqrt_cell #(.RW(RW)) u_cell (
      .clk(clk),
      .in_rem(sq_rem[i]), .in_root(sq_root[i]), .in_rad(sq_rad[i]),
      .out_rem(sq_rem[i+1]), .out_root(sq_root[i+1]), .out_rad(sq_rad[i+1])
    );
  end

  // root finishes early; hold it until the magnitude catches up
  always_ff @(posedge clk) begin
    rt_dly_r[0] <= sq_root[RW];
    for (int i = 1; i < DLY; i++) begin
      rt_dly_r[i] <= rt_dly_r[i-1];
    end
  end

  assign mc_tag = tag_t'(mc_side[MAGW]);
  assign mag = mc_rem[MAGW][MAGW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st5_v_r <= 1'b0;
    end else begin
      st5_v_r <= mc_v[MAGW];
    end
  end

  always_ff @(posedge clk) begin
    st5_tag_r <= mc_tag;
    prodx_r <= PRODW'(mag) * PRODW'(mc_tag.ax);
    prody_r <= PRODW'(mag) * PRODW'(mc_tag.ay);
    r5_r <= rt_dly_r[DLY-1];
  end

  // ---------------- axis divider chains ----------------
  assign xc_v[0] = st5_v_r;
  assign xc_rem[0] = (RW + PRODW + 1)'(prodx_r);
  assign yc_rem[0] = (RW + PRODW + 1)'(prody_r);
  assign xc_dvs[0] = r5_r;
  assign yc_dvs[0] = r5_r;
  assign xc_side[0] = st5_tag_r;

  for (genvar i = 0; i < PRODW; i++) begin : g_axis
    nbgs_div_cell #(.DW(RW), .QW(PRODW), .SW(TAGW)) u_xcell (
      .clk(clk), .rst_n(rst_n),
      .in_v(xc_v[i]), .in_rem(xc_rem[i]), .in_dvs(xc_dvs[i]), .in_side(xc_side[i]),
      .out_v(xc_v[i+1]), .out_rem(xc_rem[i+1]), .out_dvs(xc_dvs[i+1]),
      .out_side(xc_side[i+1])
    );
    nbgs_div_cell #(.DW(RW), .QW(PRODW), .SW(1)) u_ycell (
      .clk(clk), .rst_n(rst_n),
      .in_v(xc_v[i]), .in_rem(yc_rem[i]), .in_dvs(yc_dvs[i]), .in_side(1'b0),
      .out_v(), .out_rem(yc_rem[i+1]), .out_dvs(yc_dvs[i+1]), .out_side()
    );
  end

  // ---------------- pull accumulation ----------------
  always_comb begin
    fin_tag = tag_t'(xc_side[PRODW]);
    cx = xc_rem[PRODW][PRODW-1:0];
    cy = yc_rem[PRODW][PRODW-1:0];
    // anything past 2^33 saturates the sum anyway
    cmx = (cx > PRODW'(PULL_CLAMP)) ? PULL_CLAMP : cx[33:0];
    cmy = (cy > PRODW'(PULL_CLAMP)) ? PULL_CLAMP : cy[33:0];
    pullx = fin_tag.zf ? '0 : (fin_tag.sx ? -36'(cmx) : 36'(cmx));
    pully = fin_tag.zf ? '0 : (fin_tag.sy ? -36'(cmy) : 36'(cmy));
    sumx = (fin_tag.first ? '0 : 36'(accx_r)) + pullx;
    sumy = (fin_tag.first ? '0 : 36'(accy_r)) + pully;
    satx = sat32(sumx);
    saty = sat32(sumy);
  end

  assign acc_done = xc_v[PRODW] && fin_tag.fin;

  always_ff @(posedge clk) begin
    if (xc_v[PRODW]) begin
      accx_r <= satx[31:0];
      accy_r <= saty[31:0];
    end
  end

  // ---------------- move pass ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_v_r <= 1'b0;
    end else begin
      upd_v_r <= upd_issue;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= up_p_r;
  end

  always_comb begin
    nx_sat = sat32(36'(pxa_r) + 36'(fx_rd_r) + 36'(vx_rd_r));
    ny_sat = sat32(36'(pya_r) + 36'(fy_rd_r) + 36'(vy_rd_r));
    vx_sat = sat32(36'(signed'(nx_sat[31:0])) - 36'(pxa_r));
    vy_sat = sat32(36'(signed'(ny_sat[31:0])) - 36'(pya_r));
  end

endmodule

FILE: tb/tb_nbody_gravity_step_core.sv
// Testbench for nbody_gravity_step_core: directed and random items checked against a predictor.
module tb_nbody_gravity_step_core;
  import nbgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART = DEF_MAX_PARTICLES;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  func;
    logic [9:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
  } op_item_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        ov;
  } answer_t;

  class gravity_board;
    longint px[NPART], py[NPART], vx[NPART], vy[NPART];
    longint count_reg, mass_reg;
    answer_t answers[$];
    int errors;

    function new();
      count_reg = 0;
      mass_reg = 0;
      errors = 0;
      foreach (px[i]) begin
        px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDXW-1:0] index, logic [CFG_DW-1:0] data);
      if (index == CFG_PARTICLE_COUNT) count_reg = data[10:0];
      else mass_reg = data;
    endfunction

    function longint sat(longint v, ref bit ov);
      if (v > 64'sd2147483647) begin
        ov = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        ov = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit advance();
      bit ov;
      int n;
      longint unsigned m2, ax, ay, s, q, r, mag, cx, cy;
      longint dx, dy, nx, ny;
      longint fx[NPART], fy[NPART];
      ov = 0;
      n = (count_reg > NPART) ? NPART : int'(count_reg);
      m2 = (mass_reg * mass_reg) >> MASS_FRAC;
      for (int p = 0; p < n; p++) begin
        fx[p] = 0;
        fy[p] = 0;
        for (int a = 0; a < n; a++) begin
          if (a == p) continue;
          dx = px[a] - px[p];
          dy = py[a] - py[p];
          ax = longint'(dx < 0 ? -dx : dx) >> HALF_SHIFT;
          ay = longint'(dy < 0 ? -dy : dy) >> HALF_SHIFT;
          s = ax * ax + ay * ay;
          if (s == 0) continue;  // coincident pair
          r = root(s);
          q = (s < (64'd1 << (2 * FINE_BITS))) ? (64'd1 << (2 * FINE_BITS)) : s;
          mag = (m2 << MAG_SHIFT) / q;
          cx = (mag * ax) / r;
          cy = (mag * ay) / r;
          fx[p] = sat(fx[p] + (dx < 0 ? -longint'(cx) : longint'(cx)), ov);
          fy[p] = sat(fy[p] + (dy < 0 ? -longint'(cy) : longint'(cy)), ov);
        end
      end
      for (int p = 0; p < n; p++) begin
        nx = sat(px[p] + fx[p] + vx[p], ov);
        ny = sat(py[p] + fy[p] + vy[p], ov);
        vx[p] = sat(nx - px[p], ov);
        vy[p] = sat(ny - py[p], ov);
        px[p] = nx;
        py[p] = ny;
      end
      return ov;
    endfunction

    function void note_input(op_item_t it);
      answer_t ans;
      ans.func = it.func;
      ans.rx = 0;
      ans.ry = 0;
      ans.ov = 0;
      case (it.func)
        FUNC_LOAD: begin
          px[it.idx] = longint'(signed'(it.x));
          py[it.idx] = longint'(signed'(it.y));
          vx[it.idx] = 0;
          vy[it.idx] = 0;
        end
        FUNC_STEP: ans.ov = advance();
        FUNC_READ: begin
          ans.rx = px[it.idx][31:0];
          ans.ry = py[it.idx][31:0];
        end
        default: ;
      endcase
      answers.push_back(ans);
    endfunction

    function void check_result(logic [1:0] func, logic [OUT_TDW-1:0] data);
      answer_t exp_ans;
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result func=%0d data=%h", func, data);
        return;
      end
      exp_ans = answers.pop_front();
      if (func !== exp_ans.func || data[31:0] !== exp_ans.rx || data[63:32] !== exp_ans.ry ||
          data[64] !== exp_ans.ov || data[OUT_TDW-1:65] !== '0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp func=%0d x=%h y=%h ov=%b, got func=%0d x=%h y=%h ov=%b",
                   exp_ans.func, exp_ans.rx, exp_ans.ry, exp_ans.ov,
                   func, data[31:0], data[63:32], data[64]);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_TDW-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_TDW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDXW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  gravity_board board = new();
  op_item_t batch[$];
  bit loaded[NPART];
  int loaded_list[$];
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  nbody_gravity_step_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[nbody_gravity_step_core] ERROR");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready)
      board.note_input('{in_tuser, in_tdata[9:0], in_tdata[41:10], in_tdata[73:42]});
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tuser, out_tdata);
  end

  // receiver stall pattern: random modes of always ready, ready half the time, or a quarter of it
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic write_cfg(logic [CFG_IDXW-1:0] index, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // called at a clock edge; within a burst a new item goes out right after the edge that took the last one
  task automatic drive_batch();
    op_item_t it;
    while (batch.size() != 0) begin
      it = batch.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= it.func;
      in_tdata <= {6'b0, it.y, it.x, it.idx};
      do @(posedge clk); while (!in_tready);
      if (burst_left > 0 && batch.size() != 0) begin
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 8);
      end
    end
    wait_idle();
  endtask

  function automatic void add_op(logic [1:0] func, int idx, logic [31:0] x, logic [31:0] y);
    batch.push_back('{func, idx[9:0], x, y});
    if (func == FUNC_LOAD && !loaded[idx]) begin
      loaded[idx] = 1;
      loaded_list.push_back(idx);
    end
  endfunction

  function automatic logic [31:0] pick_pos(bit wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  task automatic random_phase(int n, int items);
    logic [23:0] mass;
    bit wide;
    int k;
    case ($urandom_range(0, 3))
      0: mass = 24'h0;
      1: mass = 24'hFF_FFFF;
      2: mass = 24'h01_0000;
      default: mass = 24'($urandom);
    endcase
    wide = ($urandom_range(0, 3) == 0);
    write_cfg(CFG_PARTICLE_COUNT, 24'(n));
    write_cfg(CFG_PARTICLE_MASS, mass);
    for (int i = 0; i < n; i++) add_op(FUNC_LOAD, i, pick_pos(wide), pick_pos(wide));
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15)
        add_op(FUNC_LOAD, ($urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, NPART - 1)),
               pick_pos(wide), pick_pos(wide));
      else if (k < 50)
        add_op(FUNC_STEP, $urandom_range(0, NPART - 1), $urandom, $urandom);
      else if (k < 88)
        add_op(FUNC_READ, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
               $urandom, $urandom);
      else
        add_op(2'd3, $urandom_range(0, NPART - 1), $urandom, $urandom);
    end
    drive_batch();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty system, unknown func
    add_op(FUNC_STEP, 0, 0, 0);
    add_op(2'd3, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_batch();

    // heaviest mass at opposite corners: saturation
    write_cfg(CFG_PARTICLE_COUNT, 24'd2);
    write_cfg(CFG_PARTICLE_MASS, 24'hFF_FFFF);
    add_op(FUNC_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_op(FUNC_LOAD, 1, 32'h8000_0000, 32'h8000_0000);
    add_op(FUNC_STEP, 0, 0, 0);
    add_op(FUNC_READ, 0, 0, 0);
    add_op(FUNC_READ, 1, 0, 0);
    add_op(FUNC_STEP, 0, 0, 0);
    add_op(FUNC_READ, 1, 0, 0);
    drive_batch();

    // coincident pair plus a near one, unit mass
    write_cfg(CFG_PARTICLE_COUNT, 24'd3);
    write_cfg(CFG_PARTICLE_MASS, 24'h01_0000);
    add_op(FUNC_LOAD, 0, 32'h0, 32'h0);
    add_op(FUNC_LOAD, 1, 32'h0000_0040, 32'h0);
    add_op(FUNC_LOAD, 2, 32'h0010_0000, 32'hFFF0_0000);
    add_op(FUNC_STEP, 0, 0, 0);
    add_op(FUNC_STEP, 0, 0, 0);
    add_op(FUNC_READ, 0, 0, 0);
    add_op(FUNC_READ, 2, 0, 0);
    add_op(FUNC_LOAD, 1023, 32'h1234_5678, 32'h8765_4321);
    add_op(FUNC_READ, 1023, 0, 0);
    drive_batch();

    // count beyond store: only loads and reads while it holds
    write_cfg(CFG_PARTICLE_COUNT, 24'h7FF);
    add_op(FUNC_LOAD, 512, 32'hFFFF_FFFF, 32'h0);
    add_op(FUNC_READ, 512, 0, 0);
    add_op(FUNC_READ, 1023, 0, 0);
    drive_batch();

    for (int ph = 0; ph < 4; ph++) random_phase($urandom_range(2, 8), 17);

    if (board.errors == 0 && board.answers.size() == 0) begin
      $display("[nbody_gravity_step_core] OK");
    end else begin
      $display("[nbody_gravity_step_core] ERROR");
    end
    $finish;
  end
endmodule
